// ===== rtl/core/ritoa_pkg.sv =====
// shared constants, types and helpers for the radix integer to ascii converter
package ritoa_pkg;

  localparam int VALUE_W    = 64;
  localparam int DIV_W      = 64;
  localparam int DIGIT_BITS = 4;
  localparam int PASS_STEPS = DIV_W / DIGIT_BITS;
  localparam int STEP_W     = $clog2(PASS_STEPS);
  localparam int RADIX_W    = 6;
  localparam int MAX_DIGITS = 64;
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int CHAR_W     = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] DEC_MAX     = RADIX_W'(9);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  CHAR_ALPHA  = CHAR_W'(97 - 10);

  localparam logic [DIV_W-1:0] VALUE_MASK = DIV_W'((65'(1) << VALUE_W) - 65'(1));

  typedef struct packed {
    logic load;
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic done;
    logic qzero;
  } div_sts_t;

  function automatic logic [CHAR_W-1:0] to_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {{(CHAR_W-RADIX_W){1'b0}}, d};
    if (d > DEC_MAX) begin
      return dx + CHAR_ALPHA;
    end
    return dx + CHAR_ZERO;
  endfunction

endpackage

// ===== rtl/core/ritoa_div.sv =====
// digit-serial long division of a word by the radix, a few bits per cycle
module ritoa_div (
  input  logic                           clk,
  input  logic                           rst,
  input  ritoa_pkg::div_ctl_t            ctl,
  input  logic [ritoa_pkg::DIV_W-1:0]    load_value,
  input  logic [ritoa_pkg::RADIX_W-1:0]  radix,
  output ritoa_pkg::div_sts_t            sts,
  output logic [ritoa_pkg::RADIX_W-1:0]  rem
);
  import ritoa_pkg::*;

  logic [DIV_W-1:0]   num;
  logic [DIV_W-1:0]   num_next;
  logic [RADIX_W-1:0] rem_next;
  logic [STEP_W-1:0]  cnt;
  logic               busy;
  logic               done;
  logic               qnz;
  logic               qany;

  always_comb begin
    logic [RADIX_W:0] t;
    num_next = num;
    rem_next = rem;
    qany     = 1'b0;
    for (int i = 0; i < DIGIT_BITS; i++) begin
      t        = {rem_next, num_next[DIV_W-1]};
      num_next = {num_next[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, radix}) begin
        t           = t - {1'b0, radix};
        num_next[0] = 1'b1;
        qany        = 1'b1;
      end
      rem_next = t[RADIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        if (cnt == STEP_W'(PASS_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
      if (ctl.start) begin
        busy <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      num <= num_next;
      rem <= rem_next;
      qnz <= qnz | qany;
      cnt <= cnt + STEP_W'(1);
    end
    if (ctl.start) begin
      cnt <= '0;
      rem <= '0;
      qnz <= 1'b0;
    end
    if (ctl.load) begin
      num <= load_value;
    end
  end

  assign sts.done  = done;
  assign sts.qzero = ~qnz;

endmodule

// ===== rtl/core/radix_integer_to_ascii.sv =====
// top level: integer to ascii digits in a configurable radix
// sequence: one division pass per digit, remainders stored until the quotient is zero,
// then each digit is read from the store and loaded to the output, most significant first
// throughput: one integer at a time, next accepted once the last digit is loaded
// the divider walks 4 bits of the 64-bit word per cycle while busy, the whole word each pass
// rst is synchronous: radix returns to 10, no word pending; the digit store is not cleared
module radix_integer_to_ascii (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [63:0]                   s_tdata,   // value[63:0]
  input  logic                          s_tuser,   // signed_mode
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // digit_char[7:0]
  output logic                          m_tlast,   // last_digit
  input  logic                          cfg_wen,
  input  logic [ritoa_pkg::RADIX_W-1:0] cfg_wdata
);
  import ritoa_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_LD   = 2'd3;

  logic [1:0]         state;
  logic [RADIX_W-1:0] radix;
  logic [RADIX_W-1:0] radix_eff;
  logic [IDX_W-1:0]   wr_idx;
  logic [IDX_W-1:0]   rd_idx;
  logic [RADIX_W-1:0] dmem [MAX_DIGITS];
  logic [RADIX_W-1:0] rdata;
  logic [DIV_W-1:0]   mag;
  logic [31:0]        low;
  div_ctl_t           dctl;
  div_sts_t           dsts;
  logic [RADIX_W-1:0] drem;
  logic               accept;
  logic               load_out;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign load_out = (state == ST_LD) && (!m_tvalid || m_tready);

  always_comb begin
    if (radix < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      radix_eff = RADIX_MAX;
    end else begin
      radix_eff = radix;
    end
  end

  always_comb begin
    low = s_tdata[31:0];
    if (s_tuser) begin
      if (low[31]) begin
        mag = {{(DIV_W-32){1'b0}}, (~low + 32'd1)};
      end else begin
        mag = {{(DIV_W-32){1'b0}}, low};
      end
    end else begin
      mag = s_tdata & VALUE_MASK;
    end
  end

  always_comb begin
    dctl.load  = accept;
    dctl.start = accept ||
                 ((state == ST_DIV) && dsts.done && !dsts.qzero &&
                  (wr_idx != IDX_W'(MAX_DIGITS - 1)));
  end

  ritoa_div u_div (
    .clk        (clk),
    .rst        (rst),
    .ctl        (dctl),
    .load_value (mag),
    .radix      (radix_eff),
    .sts        (dsts),
    .rem        (drem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_wen) begin
      radix <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (dsts.done && (dsts.qzero || wr_idx == IDX_W'(MAX_DIGITS - 1))) begin
            state <= ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_LD;
        end
        ST_LD: begin
          if (load_out) begin
            state <= (rd_idx == '0) ? ST_IDLE : ST_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wr_idx <= '0;
    end else if (state == ST_DIV && dsts.done) begin
      wr_idx <= wr_idx + IDX_W'(1);
      rd_idx <= wr_idx;
    end else if (load_out) begin
      rd_idx <= rd_idx - IDX_W'(1);
    end
    if (load_out) begin
      m_tdata <= to_ascii(rdata);
      m_tlast <= (rd_idx == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIV && dsts.done) begin
      dmem[wr_idx] <= drem;
    end
    rdata <= dmem[rd_idx];
  end

endmodule

// ===== rtl/core/ritoa_chk.sv =====
// port-level checker for the radix integer to ascii converter, with its bind
module ritoa_chk (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word dropped or changed while stalled");

  a_ascii: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata >= 8'd48 && m_tdata <= 8'd57) ||
                  (m_tdata >= 8'd97 && m_tdata <= 8'd122)))
    else $error("output word is not a digit or lower-case letter");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again straight after an accept");

  a_ready_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> s_tready && !m_tvalid)
    else $error("not idle after reset");

endmodule

bind radix_integer_to_ascii ritoa_chk u_ritoa_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
